@@ rtl/core/smalu_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack machine arithmetic unit package
// Opcodes, status codes, stack sizing and the types shared between the
// sequencer and the iterative multiply/divide unit.
// ----------------------------------------------------------------------------
package smalu_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

   localparam int WORD_W   = 32;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int DEPTH_OUT_W = 7;
   localparam int COUNT_W  = $clog2(WORD_W);

   localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_MOD  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   typedef enum logic [1:0] {
      MODE_MUL = 2'd0,
      MODE_DIV = 2'd1,
      MODE_REM = 2'd2
   } iter_mode_type;

   typedef struct packed {
      logic          start;
      iter_mode_type mode;
   } iter_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_stat_type;

endpackage

@@ rtl/core/smalu_if.sv @@
// ----------------------------------------------------------------------------
// Stack machine arithmetic unit channels
// Valid/ready channels for opcode transactions and result transactions.
// ----------------------------------------------------------------------------
interface smalu_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [smalu_pkg::OPCODE_W-1:0]           opcode;
   logic signed [smalu_pkg::WORD_W-1:0]      push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface smalu_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [smalu_pkg::STATUS_W-1:0]           status;
   logic signed [smalu_pkg::WORD_W-1:0]      top_value;
   logic [smalu_pkg::DEPTH_OUT_W-1:0]        depth;

   modport source (output valid, output status, output top_value, output depth, input ready);
   modport sink   (input valid, input status, input top_value, input depth, output ready);
endinterface

@@ rtl/core/smalu_iter.sv @@
// ----------------------------------------------------------------------------
// Stack machine iterative multiply/divide unit
// One shared 33-bit adder serves a shift-add multiplier, a restoring
// divider on magnitudes and the final sign correction.
// ----------------------------------------------------------------------------
module smalu_iter (
   input  logic                            clock,
   input  logic                            reset,
   input  smalu_pkg::iter_ctrl_type        ctrl,
   input  logic [smalu_pkg::WORD_W-1:0]    opa,
   input  logic [smalu_pkg::WORD_W-1:0]    opb,
   output smalu_pkg::iter_stat_type        stat,
   output logic [smalu_pkg::WORD_W-1:0]    result
);

   typedef enum logic [2:0] {
      IT_IDLE = 3'b001,
      IT_RUN  = 3'b010,
      IT_FIX  = 3'b100
   } it_state_type;

   it_state_type                         state_ff, state_in;
   smalu_pkg::iter_mode_type             mode_ff, mode_in;
   logic [smalu_pkg::WORD_W-1:0]         acc_ff, acc_in;
   logic [smalu_pkg::WORD_W-1:0]         quo_ff, quo_in;
   logic [smalu_pkg::WORD_W-1:0]         opd_ff, opd_in;
   logic [smalu_pkg::COUNT_W-1:0]        cnt_ff, cnt_in;
   logic                                 neg_ff, neg_in;
   logic [smalu_pkg::WORD_W:0]           add_x, add_y, add_sum;
   logic                                 add_cin;
   logic [smalu_pkg::WORD_W-1:0]         fix_val;
   logic                                 sign_a, sign_b;

   assign sign_a  = opa[smalu_pkg::WORD_W-1];
   assign sign_b  = opb[smalu_pkg::WORD_W-1];
   assign fix_val = (mode_ff == smalu_pkg::MODE_DIV) ? quo_ff : acc_ff;
   assign add_sum = add_x + add_y + {{smalu_pkg::WORD_W{1'b0}}, add_cin};

   always_comb begin
      add_x   = {1'b0, acc_ff};
      add_y   = '0;
      add_cin = 1'b0;
      unique case (state_ff)
         IT_RUN: begin
            if (mode_ff == smalu_pkg::MODE_MUL) begin
               add_x = {1'b0, acc_ff};
               add_y = quo_ff[0] ? {1'b0, opd_ff} : '0;
            end else begin
               add_x   = {acc_ff, quo_ff[smalu_pkg::WORD_W-1]};
               add_y   = ~{1'b0, opd_ff};
               add_cin = 1'b1;
            end
         end
         IT_FIX: begin
            add_x   = neg_ff ? {1'b0, ~fix_val} : {1'b0, fix_val};
            add_cin = neg_ff;
         end
         default: begin
            add_x = {1'b0, acc_ff};
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      opd_in   = opd_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         IT_IDLE: begin
            if (ctrl.start) begin
               mode_in  = ctrl.mode;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = IT_RUN;
               if (ctrl.mode == smalu_pkg::MODE_MUL) begin
                  opd_in = opa;
                  quo_in = opb;
                  neg_in = 1'b0;
               end else begin
                  quo_in = sign_a ? (~opa + 1'b1) : opa;
                  opd_in = sign_b ? (~opb + 1'b1) : opb;
                  neg_in = (ctrl.mode == smalu_pkg::MODE_DIV) ? (sign_a ^ sign_b) : sign_a;
               end
            end
         end
         IT_RUN: begin
            if (mode_ff == smalu_pkg::MODE_MUL) begin
               acc_in = add_sum[smalu_pkg::WORD_W-1:0];
               opd_in = {opd_ff[smalu_pkg::WORD_W-2:0], 1'b0};
               quo_in = {1'b0, quo_ff[smalu_pkg::WORD_W-1:1]};
            end else if (add_sum[smalu_pkg::WORD_W]) begin
               acc_in = {acc_ff[smalu_pkg::WORD_W-2:0], quo_ff[smalu_pkg::WORD_W-1]};
               quo_in = {quo_ff[smalu_pkg::WORD_W-2:0], 1'b0};
            end else begin
               acc_in = add_sum[smalu_pkg::WORD_W-1:0];
               quo_in = {quo_ff[smalu_pkg::WORD_W-2:0], 1'b1};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == {smalu_pkg::COUNT_W{1'b1}}) begin
               state_in = IT_FIX;
            end
         end
         IT_FIX: begin
            state_in = IT_IDLE;
         end
         default: begin
            state_in = IT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff <= mode_in;
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
      opd_ff  <= opd_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
   end

   assign stat.busy = (state_ff != IT_IDLE);
   assign stat.done = (state_ff == IT_FIX);
   assign result    = add_sum[smalu_pkg::WORD_W-1:0];

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      (ctrl.start && state_ff != IT_IDLE) |-> 1'b0)
      else $error("Iterative unit started while busy.");

   a_fix_follows_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IT_FIX) |-> $past(state_ff) == IT_RUN)
      else $error("Sign correction not preceded by the last iteration.");

   a_run_ends_in_fix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IT_RUN && cnt_ff == {smalu_pkg::COUNT_W{1'b1}}) |=> state_ff == IT_FIX)
      else $error("Last iteration not followed by sign correction.");

endmodule

@@ rtl/core/stack_machine_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Stack machine arithmetic unit
// Bounded stack of signed words with push, add, sub, mul, div and mod.
//
//   Channel   Direction  Handshake     Contents
//   req_bus   in         valid/ready   opcode, push_value
//   rsp_bus   out        valid/ready   status, top_value, depth
//
// Push, errors and unused opcodes pass from S_IDLE straight to S_DONE.
// Add and sub pass through S_READ first, for the stack memory read.
// Mul, div and mod pass through S_READ and S_ITER: the memory read, 32
// iterations of the shared multiply/divide unit and a sign correction step.
// A new transaction is accepted only while the sequencer is idle; a result
// waiting on rsp_bus holds back completion of the following transaction only.
// Reset clears the sequencer and the stack depth; the stack memory needs no
// clearing pass.
// ----------------------------------------------------------------------------
module stack_machine_arithmetic_unit (
   input  logic           clock,
   input  logic           reset,
   smalu_req_if.sink      req_bus,
   smalu_rsp_if.source    rsp_bus
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_ITER = 5'b00100,
      S_DONE = 5'b01000,
      S_HOLD = 5'b10000
   } state_type;

   state_type                               state_ff, state_in;
   logic [smalu_pkg::DEPTH_W-1:0]           depth_ff, depth_in;
   logic [smalu_pkg::WORD_W-1:0]            top_ff, top_in;
   logic [smalu_pkg::OPCODE_W-1:0]          op_ff, op_in;
   logic [smalu_pkg::STATUS_W-1:0]          res_status_ff, res_status_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [smalu_pkg::STATUS_W-1:0]          rsp_status_ff, rsp_status_in;
   logic [smalu_pkg::WORD_W-1:0]            rsp_top_ff, rsp_top_in;
   logic [smalu_pkg::DEPTH_OUT_W-1:0]       rsp_depth_ff, rsp_depth_in;

   logic [smalu_pkg::WORD_W-1:0]            stack_mem [smalu_pkg::STACK_DEPTH];
   logic [smalu_pkg::WORD_W-1:0]            rd_data_ff;
   logic [smalu_pkg::ADDR_W-1:0]            rd_addr, wr_addr;
   logic                                    wr_en;
   logic [smalu_pkg::WORD_W-1:0]            wr_data;
   logic [smalu_pkg::DEPTH_W-1:0]           second_idx;

   smalu_pkg::iter_ctrl_type                iter_ctrl;
   smalu_pkg::iter_stat_type                iter_stat;
   logic [smalu_pkg::WORD_W-1:0]            iter_result;
   logic                                    accept;
   logic                                    is_arith, is_divide, rsp_free;

   assign second_idx = depth_ff - smalu_pkg::DEPTH_W'(2);
   assign rd_addr    = second_idx[smalu_pkg::ADDR_W-1:0];
   assign accept     = req_bus.valid && (state_ff == S_IDLE);
   assign is_arith   = (req_bus.opcode >= smalu_pkg::OP_ADD) &&
                       (req_bus.opcode <= smalu_pkg::OP_MOD);
   assign is_divide  = (req_bus.opcode == smalu_pkg::OP_DIV) ||
                       (req_bus.opcode == smalu_pkg::OP_MOD);
   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;

   smalu_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (iter_ctrl),
      .opa    (rd_data_ff),
      .opb    (top_ff),
      .stat   (iter_stat),
      .result (iter_result)
   );

   always_comb begin
      state_in       = state_ff;
      depth_in       = depth_ff;
      top_in         = top_ff;
      op_in          = op_ff;
      res_status_in  = res_status_ff;
      wr_en          = 1'b0;
      wr_addr        = rd_addr;
      wr_data        = iter_result;
      iter_ctrl.start = 1'b0;
      iter_ctrl.mode  = smalu_pkg::MODE_MUL;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in         = req_bus.opcode;
               res_status_in = smalu_pkg::ST_OK;
               state_in      = S_DONE;
               priority if (req_bus.opcode == smalu_pkg::OP_PUSH) begin
                  if (depth_ff == smalu_pkg::DEPTH_W'(smalu_pkg::STACK_DEPTH)) begin
                     res_status_in = smalu_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = depth_ff[smalu_pkg::ADDR_W-1:0];
                     wr_data  = req_bus.push_value;
                     top_in   = req_bus.push_value;
                     depth_in = depth_ff + 1'b1;
                  end
               end else if (is_arith) begin
                  priority if (depth_ff < smalu_pkg::DEPTH_W'(2)) begin
                     res_status_in = smalu_pkg::ST_SHORT;
                  end else if (is_divide && (top_ff == '0)) begin
                     res_status_in = smalu_pkg::ST_DIVZERO;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  res_status_in = smalu_pkg::ST_OK;
               end
            end
         end
         S_READ: begin
            if ((op_ff == smalu_pkg::OP_ADD) || (op_ff == smalu_pkg::OP_SUB)) begin
               wr_en    = 1'b1;
               wr_data  = (op_ff == smalu_pkg::OP_ADD) ? (rd_data_ff + top_ff)
                                                       : (rd_data_ff - top_ff);
               top_in   = wr_data;
               depth_in = depth_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               iter_ctrl.start = 1'b1;
               unique case (op_ff)
                  smalu_pkg::OP_DIV: iter_ctrl.mode = smalu_pkg::MODE_DIV;
                  smalu_pkg::OP_MOD: iter_ctrl.mode = smalu_pkg::MODE_REM;
                  default:           iter_ctrl.mode = smalu_pkg::MODE_MUL;
               endcase
               state_in = S_ITER;
            end
         end
         S_ITER: begin
            if (iter_stat.done) begin
               wr_en    = 1'b1;
               wr_data  = iter_result;
               top_in   = iter_result;
               depth_in = depth_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (((state_ff == S_DONE) || (state_ff == S_HOLD)) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_top_in    = (depth_ff == '0) ? '0 : top_ff;
         rsp_depth_in  = smalu_pkg::DEPTH_OUT_W'(depth_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.top_value = rsp_top_ff;
   assign rsp_bus.depth     = rsp_depth_ff;

   a_depth_bounded: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= smalu_pkg::DEPTH_W'(smalu_pkg::STACK_DEPTH))
      else $error("Stack depth exceeds the stack size.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_status_ff == smalu_pkg::ST_FULL) |->
      depth_ff == smalu_pkg::DEPTH_W'(smalu_pkg::STACK_DEPTH))
      else $error("Full status reported on a stack that is not full.");

   a_iter_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ITER) |-> iter_stat.busy)
      else $error("Sequencer waits on an idle multiply/divide unit.");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("Accepted transaction did not leave the idle state.");

endmodule
